// ===== rtl/jsfv_pkg.sv =====
package jsfv_pkg;

  localparam int unsigned TEXT_BYTE_W    = 8;
  localparam int unsigned VALUE_LENGTH_W = 11;
  localparam int unsigned NAME_BYTES_W   = 64;
  localparam int unsigned NAME_LENGTH_W  = 4;
  localparam int unsigned CFG_INDEX_W    = 1;
  localparam int unsigned CFG_DATA_W     = 64;

  // Room for the decoded value; the longest legal value is one less.
  localparam int unsigned VALUE_CAPACITY = 2048;
  localparam int unsigned COUNT_W        = $clog2(VALUE_CAPACITY);

  localparam logic [CFG_INDEX_W-1:0] REG_FIELD_NAME_BYTES  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FIELD_NAME_LENGTH = 1'b1;

endpackage

// ===== rtl/jsfv_if.sv =====
interface jsfv_text_if
  import jsfv_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [TEXT_BYTE_W-1:0] text_byte;
  logic                   is_last;

  modport source (output valid, output text_byte, output is_last, input ready);
  modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

interface jsfv_verdict_if
  import jsfv_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic                      accepted;
  logic [VALUE_LENGTH_W-1:0] value_length;

  modport source (output valid, output accepted, output value_length, input ready);
  modport sink   (input valid, input accepted, input value_length, output ready);
endinterface

interface jsfv_cfg_if
  import jsfv_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/json_single_field_validator_top.sv =====
// Single-field JSON object checker: {"key":"value"} with optional whitespace.
//
// Channels:
//   text_in : one text byte per request, is_last marks the final byte of a text.
//             A zero byte ends the text; bytes after it are dropped until is_last.
//   verdict : one request per text, issued for the byte marked is_last.
//             accepted = 1 when the text is exactly one object whose key equals
//             the configured field name and whose value is a non-empty string;
//             value_length then holds the decoded value length, else zero.
//   cfg     : index 0 writes field_name_bytes (first char in lowest byte),
//             index 1 writes field_name_length (low 4 bits). Always ready; write
//             only while no text is in flight.
// Throughput is one byte per cycle: the parse step is one level of small
// decode logic between the input register and the parse-state registers.
// A final byte is held in the input register, and its verdict then in the
// verdict register. When verdict stalls, a held verdict blocks only the
// next final byte; other bytes keep flowing until that byte reaches the stage.
// Reset clears the parse state, both valid flags and the registers to key
// bytes zero and length one.
module json_single_field_validator_top
  import jsfv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  jsfv_text_if.sink       text_in,
  jsfv_verdict_if.source  verdict,
  jsfv_cfg_if.sink        cfg
);

  typedef enum logic [3:0] {
    PH_OPEN,
    PH_KEY_START,
    PH_KEY,
    PH_KEY_ESC,
    PH_COLON,
    PH_VAL_START,
    PH_VAL,
    PH_VAL_ESC,
    PH_CLOSE,
    PH_TAIL,
    PH_FAIL
  } phase_t;

  localparam logic [COUNT_W-1:0] VALUE_LIMIT = COUNT_W'(VALUE_CAPACITY - 1);

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction

  // Decoded byte of an escape letter; bit 8 flags a legal escape.
  function automatic logic [8:0] unescape(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h22, 8'h5C, 8'h2F: r = {1'b1, c};
      8'h62:               r = {1'b1, 8'h08};
      8'h66:               r = {1'b1, 8'h0C};
      8'h6E:               r = {1'b1, 8'h0A};
      8'h72:               r = {1'b1, 8'h0D};
      8'h74:               r = {1'b1, 8'h09};
      default:             r = 9'h000;
    endcase
    return r;
  endfunction

  // Configuration registers
  logic [NAME_BYTES_W-1:0]  field_name_bytes;
  logic [NAME_LENGTH_W-1:0] field_name_length;

  // Input register
  logic                   s1_valid;
  logic [TEXT_BYTE_W-1:0] s1_byte;
  logic                   s1_last;
  logic                   s1_advance;

  // Parse state
  phase_t             phase, phase_next;
  logic [3:0]         key_position, key_position_next;
  logic               key_mismatch, key_mismatch_next;
  logic [COUNT_W-1:0] value_count, value_count_next;
  logic               text_ended, text_ended_next;

  // Verdict register
  logic                      out_valid;
  logic                      out_accepted, out_accepted_next;
  logic [VALUE_LENGTH_W-1:0] out_length, out_length_next;

  logic [3:0] len_eff;
  logic [8:0] esc;
  logic [7:0] key_char;
  logic       key_hit;

  assign cfg.ready = 1'b1;

  // A final byte may only leave the input register when the verdict slot is free.
  assign s1_advance    = s1_valid && (!s1_last || !out_valid || verdict.ready);
  assign text_in.ready = !s1_valid || s1_advance;

  assign verdict.valid        = out_valid;
  assign verdict.accepted     = out_accepted;
  assign verdict.value_length = out_length;

  assign len_eff  = (field_name_length > 4'd8) ? 4'd8 : field_name_length;
  assign esc      = unescape(s1_byte);
  assign key_char = (phase == PH_KEY_ESC) ? esc[7:0] : s1_byte;
  // Key positions beyond the name length never index the name bytes.
  assign key_hit  = !key_mismatch && (key_position < len_eff) &&
                    (field_name_bytes[{key_position[2:0], 3'b000} +: 8] == key_char);

  always_comb begin
    phase_next        = phase;
    key_position_next = key_position;
    key_mismatch_next = key_mismatch;
    value_count_next  = value_count;
    text_ended_next   = text_ended;

    if (!text_ended) begin
      if (s1_byte == 8'h00) begin
        text_ended_next = 1'b1;
      end else begin
        unique case (phase)
          PH_OPEN: begin
            if (!is_space(s1_byte)) phase_next = (s1_byte == 8'h7B) ? PH_KEY_START : PH_FAIL;
          end
          PH_KEY_START: begin
            if (!is_space(s1_byte)) phase_next = (s1_byte == 8'h22) ? PH_KEY : PH_FAIL;
          end
          PH_KEY: begin
            if (s1_byte == 8'h22) begin
              phase_next = (key_mismatch || len_eff == 4'd0 || key_position != len_eff)
                           ? PH_FAIL : PH_COLON;
            end else if (s1_byte == 8'h5C) begin
              phase_next = PH_KEY_ESC;
            end else if (s1_byte < 8'h20) begin
              phase_next = PH_FAIL;
            end else if (key_hit) begin
              key_position_next = key_position + 4'd1;
            end else begin
              key_mismatch_next = 1'b1;
            end
          end
          PH_KEY_ESC: begin
            if (esc[8]) begin
              phase_next = PH_KEY;
              if (key_hit) key_position_next = key_position + 4'd1;
              else         key_mismatch_next = 1'b1;
            end else begin
              phase_next = PH_FAIL;
            end
          end
          PH_COLON: begin
            if (!is_space(s1_byte)) phase_next = (s1_byte == 8'h3A) ? PH_VAL_START : PH_FAIL;
          end
          PH_VAL_START: begin
            if (!is_space(s1_byte)) phase_next = (s1_byte == 8'h22) ? PH_VAL : PH_FAIL;
          end
          PH_VAL: begin
            if (s1_byte == 8'h22) begin
              phase_next = (value_count == '0) ? PH_FAIL : PH_CLOSE;
            end else if (s1_byte == 8'h5C) begin
              phase_next = PH_VAL_ESC;
            end else if (s1_byte < 8'h20 || value_count >= VALUE_LIMIT) begin
              phase_next = PH_FAIL;
            end else begin
              value_count_next = value_count + COUNT_W'(1);
            end
          end
          PH_VAL_ESC: begin
            if (esc[8]) begin
              // Compare before the increment, so a wrapped count cannot pass the check.
              value_count_next = value_count + COUNT_W'(1);
              phase_next = (value_count >= VALUE_LIMIT - COUNT_W'(1)) ? PH_FAIL : PH_VAL;
            end else begin
              phase_next = PH_FAIL;
            end
          end
          PH_CLOSE: begin
            if (!is_space(s1_byte)) phase_next = (s1_byte == 8'h7D) ? PH_TAIL : PH_FAIL;
          end
          PH_TAIL: begin
            if (!is_space(s1_byte)) phase_next = PH_FAIL;
          end
          default: phase_next = PH_FAIL;
        endcase
      end
    end

    out_accepted_next = (phase_next == PH_TAIL);
    out_length_next   = out_accepted_next ? VALUE_LENGTH_W'(value_count_next) : '0;

    // Start over for the next text once the verdict is formed.
    if (s1_last) begin
      phase_next        = PH_OPEN;
      key_position_next = '0;
      key_mismatch_next = 1'b0;
      value_count_next  = '0;
      text_ended_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_name_bytes  <= '0;
      field_name_length <= NAME_LENGTH_W'(1);
      s1_valid          <= 1'b0;
      phase             <= PH_OPEN;
      key_position      <= '0;
      key_mismatch      <= 1'b0;
      value_count       <= '0;
      text_ended        <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_FIELD_NAME_BYTES:  field_name_bytes  <= cfg.data;
          REG_FIELD_NAME_LENGTH: field_name_length <= cfg.data[NAME_LENGTH_W-1:0];
          default: ;
        endcase
      end

      if (text_in.ready) s1_valid <= text_in.valid;

      if (s1_advance) begin
        phase        <= phase_next;
        key_position <= key_position_next;
        key_mismatch <= key_mismatch_next;
        value_count  <= value_count_next;
        text_ended   <= text_ended_next;
      end

      if (s1_advance && s1_last) begin
        out_valid <= 1'b1;
      end else if (verdict.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: load without reset.
  always_ff @(posedge clk) begin
    if (text_in.ready && text_in.valid) begin
      s1_byte <= text_in.text_byte;
      s1_last <= text_in.is_last;
    end
    if (s1_advance && s1_last) begin
      out_accepted <= out_accepted_next;
      out_length   <= out_length_next;
    end
  end

endmodule

// ===== rtl/jsfv_checker.sv =====
module jsfv_checker
  import jsfv_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_accepted,
  input logic [VALUE_LENGTH_W-1:0] out_length
);

  // Hold a stalled verdict.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_accepted) && $stable(out_length))
    else $error("verdict changed while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_accepted |-> out_length == '0)
    else $error("rejected verdict carries a length");

  a_accept_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_accepted |-> out_length != '0)
    else $error("accepted verdict with bad length");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("verdict valid right after reset");

endmodule

bind json_single_field_validator_top jsfv_checker u_jsfv_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (verdict.valid),
  .out_ready    (verdict.ready),
  .out_accepted (verdict.accepted),
  .out_length   (verdict.value_length)
);

// ===== tb/json_single_field_validator_top_tb.sv =====
`timescale 1ns / 100ps

module json_single_field_validator_top_tb;
  import jsfv_pkg::*;

  localparam int CLK_HALF          = 10;
  localparam int RESET_CYCLES      = 10;
  // Extra wait once every verdict is back, before any register write.
  localparam int SETTLE_CYCLES     = 6;
  localparam int HOLD_CYCLES       = 400;
  localparam int TEXTS_PER_SETTING = 1;
  localparam int PRESSURE_TEXTS    = 3;

  // Byte codes that cannot be written as plain string literals.
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_FIRST_PRINTABLE = 8'h20;

  typedef struct packed {
    logic [TEXT_BYTE_W-1:0] text_byte;
    logic                   is_last;
  } text_req_t;

  typedef struct packed {
    logic                      accepted;
    logic [VALUE_LENGTH_W-1:0] value_length;
  } verdict_t;

  typedef enum logic [3:0] {
    P_OPEN, P_KEY_START, P_KEY, P_KEY_ESC, P_COLON, P_VAL_START,
    P_VAL, P_VAL_ESC, P_CLOSE, P_TAIL, P_FAIL
  } parse_phase_e;

  typedef enum int {
    TEXT_GOOD, TEXT_KEY_LONG, TEXT_KEY_SHORT, TEXT_KEY_WRONG, TEXT_EMPTY_VALUE,
    TEXT_BAD_ESCAPE, TEXT_RAW_CTRL, TEXT_MUTATED, TEXT_TRUNCATED, TEXT_NOISE
  } text_kind_e;

  logic clk;
  logic rst;

  jsfv_text_if    text_if ();
  jsfv_verdict_if verdict_if ();
  jsfv_cfg_if     cfg_if ();

  json_single_field_validator_top uut (
    .clk     (clk),
    .rst     (rst),
    .text_in (text_if),
    .verdict (verdict_if),
    .cfg     (cfg_if)
  );

  // Requests waiting for the driver, and verdicts owed by the block.
  text_req_t   byte_q[$];
  verdict_t    verdict_q[$];
  logic [7:0]  text_buf[$];
  text_req_t   next_req;
  verdict_t    want;
  int unsigned bytes_outstanding = 0;
  int unsigned errors = 0;

  // Idle controls: percent of cycles the sender idles / the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int send_plan [4] = '{0, 70, 0, 12};
  int recv_plan [4] = '{0, 0, 70, 12};
  logic        hold_kick = 1'b0;
  int unsigned hold_left = 0;

  // Shadow of the configuration and of the parse state.
  logic [NAME_BYTES_W-1:0]  name_bytes;
  logic [NAME_LENGTH_W-1:0] name_len;
  parse_phase_e             phase;
  int unsigned              key_pos;
  logic                     key_bad;
  int unsigned              value_count;
  logic                     text_done;

  // ---------------------------------------------------------------------------
  // Verdict predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_parse();
    phase       = P_OPEN;
    key_pos     = 0;
    key_bad     = 1'b0;
    value_count = 0;
    text_done   = 1'b0;
  endfunction

  function automatic int unsigned used_name_len();
    return (name_len > 8) ? 8 : name_len;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  // Map an escape letter to the byte it stands for; 0 for an unknown escape.
  function automatic logic decode_escape(input logic [7:0] c, output logic [7:0] dec);
    dec = c;
    case (c)
      "\"", "\\", "/": return 1'b1;
      "b": begin dec = CH_BS; return 1'b1; end
      "f": begin dec = CH_FF; return 1'b1; end
      "n": begin dec = CH_LF; return 1'b1; end
      "r": begin dec = CH_CR; return 1'b1; end
      "t": begin dec = CH_TAB; return 1'b1; end
      default: return 1'b0;
    endcase
  endfunction

  // Compare one decoded key byte against the field name; a miss sticks.
  function automatic void match_key(input logic [7:0] c);
    if (key_bad || key_pos >= used_name_len() || name_bytes[8*key_pos +: 8] != c) begin
      key_bad = 1'b1;
    end else begin
      key_pos++;
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] c);
    logic [7:0] dec;
    case (phase)
      P_OPEN: begin
        if (!is_space(c)) phase = (c == "{") ? P_KEY_START : P_FAIL;
      end
      P_KEY_START: begin
        if (!is_space(c)) phase = (c == "\"") ? P_KEY : P_FAIL;
      end
      P_KEY: begin
        if (c == "\"") begin
          phase = (key_bad || used_name_len() == 0 || key_pos != used_name_len()) ?
                  P_FAIL : P_COLON;
        end else if (c == "\\") begin
          phase = P_KEY_ESC;
        end else if (c < CH_FIRST_PRINTABLE) begin
          phase = P_FAIL;
        end else begin
          match_key(c);
        end
      end
      P_KEY_ESC: begin
        if (decode_escape(c, dec)) begin
          match_key(dec);
          phase = P_KEY;
        end else begin
          phase = P_FAIL;
        end
      end
      P_COLON: begin
        if (!is_space(c)) phase = (c == ":") ? P_VAL_START : P_FAIL;
      end
      P_VAL_START: begin
        if (!is_space(c)) phase = (c == "\"") ? P_VAL : P_FAIL;
      end
      P_VAL: begin
        if (c == "\"") begin
          phase = (value_count == 0) ? P_FAIL : P_CLOSE;
        end else if (c == "\\") begin
          phase = P_VAL_ESC;
        end else if (c < CH_FIRST_PRINTABLE || value_count + 1 >= VALUE_CAPACITY) begin
          phase = P_FAIL;
        end else begin
          value_count++;
        end
      end
      P_VAL_ESC: begin
        if (!decode_escape(c, dec)) begin
          phase = P_FAIL;
        end else begin
          // An escaped byte may never land in the last free slot.
          value_count++;
          phase = (value_count + 1 >= VALUE_CAPACITY) ? P_FAIL : P_VAL;
        end
      end
      P_CLOSE: begin
        if (!is_space(c)) phase = (c == "}") ? P_TAIL : P_FAIL;
      end
      P_TAIL: begin
        if (!is_space(c)) phase = P_FAIL;
      end
      default: phase = P_FAIL;
    endcase
  endfunction

  // Advance on one accepted byte request; a final byte owes one verdict.
  function automatic void track_text_byte(input logic [7:0] c, input logic last);
    verdict_t v;
    if (!text_done) begin
      if (c == CH_NUL) text_done = 1'b1;
      else if (phase != P_FAIL) parse_byte(c);
    end
    if (last) begin
      v.accepted     = (phase == P_TAIL);
      v.value_length = v.accepted ? value_count[VALUE_LENGTH_W-1:0] : '0;
      verdict_q.push_back(v);
      clear_parse();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, long receiver hold-off, time limit
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Count the hold-off down on its own; the monitor only looks at hold_left.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Bail out if the block hangs; a correct run needs well under a tenth of this.
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offer queued byte requests, predict on each accepted one
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      text_if.valid <= 1'b0;
    end else begin
      if (text_if.valid && text_if.ready) begin
        track_text_byte(text_if.text_byte, text_if.is_last);
        bytes_outstanding--;
      end
      // Hold the current request until it is taken; otherwise advance or idle.
      if (!text_if.valid || text_if.ready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = byte_q.pop_front();
          text_if.valid     <= 1'b1;
          text_if.text_byte <= next_req.text_byte;
          text_if.is_last   <= next_req.is_last;
        end else begin
          text_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each verdict request against the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      verdict_if.ready <= 1'b0;
    end else begin
      if (verdict_if.valid && verdict_if.ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict: accepted %0d value_length %0d",
                   $time, verdict_if.accepted, verdict_if.value_length);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (verdict_if.accepted !== want.accepted) begin
            $display("%0t: accepted mismatch: expected %0d actual %0d",
                     $time, want.accepted, verdict_if.accepted);
            errors++;
          end
          if (verdict_if.value_length !== want.value_length) begin
            $display("%0t: value_length mismatch: expected %0d actual %0d",
                     $time, want.value_length, verdict_if.value_length);
            errors++;
          end
        end
      end
      verdict_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Text building
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] ws_char(input int k);
    case (k)
      0: return " ";
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  // Bytes that need, or may take, an escape inside a string.
  function automatic logic [7:0] special_char(input int k);
    case (k)
      0: return CH_BS;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_FF;
      4: return CH_CR;
      5: return "/";
      6: return "\"";
      default: return "\\";
    endcase
  endfunction

  function automatic logic [7:0] pick_name_char();
    int r;
    r = $urandom_range(99);
    if (r < 85) return 8'($urandom_range(33, 126));
    if (r < 95) return special_char($urandom_range(7));
    return 8'($urandom_range(255));
  endfunction

  task automatic add_byte(input logic [7:0] b);
    text_buf.push_back(b);
  endtask

  task automatic add_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_ws();
    if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(1, 2)) add_byte(ws_char($urandom_range(3)));
    end
  endtask

  // Write one decoded byte into a string, escaping where the syntax needs it.
  task automatic add_enc(input logic [7:0] b);
    case (b)
      "\"", "\\": begin add_byte("\\"); add_byte(b); end
      CH_BS: begin add_byte("\\"); add_byte("b"); end
      CH_FF: begin add_byte("\\"); add_byte("f"); end
      CH_LF: begin add_byte("\\"); add_byte("n"); end
      CH_CR: begin add_byte("\\"); add_byte("r"); end
      CH_TAB: begin add_byte("\\"); add_byte("t"); end
      "/": begin
        if ($urandom_range(1) == 1) add_byte("\\");
        add_byte(b);
      end
      default: add_byte(b);
    endcase
  endtask

  task automatic add_value(input int n);
    repeat (n) begin
      if ($urandom_range(6) == 0) add_enc(special_char($urandom_range(7)));
      else add_enc(8'($urandom_range(32, 255)));
    end
  endtask

  task automatic add_key(input text_kind_e kind);
    int unsigned n;
    int unsigned i;
    int unsigned wrong_at;
    logic [7:0]  b;
    n = used_name_len();
    if (n == 0) begin
      repeat ($urandom_range(1, 3)) add_enc(8'($urandom_range(33, 126)));
    end else begin
      wrong_at = $urandom_range(n - 1);
      for (i = 0; i < ((kind == TEXT_KEY_SHORT) ? n - 1 : n); i++) begin
        b = name_bytes[8*i +: 8];
        if (kind == TEXT_KEY_WRONG && i == wrong_at) b = b ^ (8'h01 << $urandom_range(7));
        add_enc(b);
      end
      if (kind == TEXT_KEY_LONG) add_enc(8'($urandom_range(33, 126)));
    end
  endtask

  task automatic build_text(input text_kind_e kind);
    logic [7:0] c;
    logic [7:0] dec;
    int unsigned cut;
    text_buf.delete();
    if (kind == TEXT_NOISE) begin
      repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(255)));
    end else begin
      add_ws(); add_byte("{"); add_ws(); add_byte("\"");
      add_key(kind);
      add_byte("\""); add_ws(); add_byte(":"); add_ws(); add_byte("\"");
      if (kind != TEXT_EMPTY_VALUE) begin
        add_value(($urandom_range(19) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 12));
      end
      if (kind == TEXT_BAD_ESCAPE) begin
        do c = 8'($urandom_range(32, 255)); while (decode_escape(c, dec));
        add_byte("\\");
        add_byte(c);
      end
      if (kind == TEXT_RAW_CTRL) add_byte(8'($urandom_range(1, 31)));
      if ($urandom_range(1) == 1) add_value($urandom_range(0, 3));
      add_byte("\""); add_ws(); add_byte("}"); add_ws();
      if (kind == TEXT_MUTATED) begin
        text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom_range(255));
      end
      if (kind == TEXT_TRUNCATED) begin
        cut = $urandom_range(1, text_buf.size() - 1);
        while (text_buf.size() > cut) void'(text_buf.pop_back());
      end
    end
    // Sometimes end the text early with a zero byte and trail junk after it.
    if ($urandom_range(4) == 0) begin
      add_byte(CH_NUL);
      repeat ($urandom_range(3)) add_byte(8'($urandom_range(255)));
    end
  endtask

  // Hand the built text to the driver; mark the final byte.
  task automatic send_text();
    text_req_t req;
    int i;
    for (i = 0; i < text_buf.size(); i++) begin
      req.text_byte = text_buf[i];
      req.is_last   = (i == text_buf.size() - 1);
      byte_q.push_back(req);
      bytes_outstanding++;
    end
    text_buf.delete();
  endtask

  task automatic send_str(input string s);
    add_str(s);
    send_text();
  endtask

  task automatic run_random_texts(input int count);
    text_kind_e kind;
    repeat (count) begin
      if ($urandom_range(99) < 60) kind = TEXT_GOOD;
      else kind = text_kind_e'($urandom_range(int'(TEXT_KEY_LONG), int'(TEXT_NOISE)));
      build_text(kind);
      send_text();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------

  // Wait until every byte request is taken and every verdict is back, then settle.
  task automatic wait_idle();
    while (bytes_outstanding != 0 || verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == REG_FIELD_NAME_BYTES) name_bytes = d;
    else name_len = d[NAME_LENGTH_W-1:0];
  endtask

  task automatic set_field_name(input logic [CFG_DATA_W-1:0] nb, input logic [CFG_DATA_W-1:0] ld);
    write_reg(REG_FIELD_NAME_BYTES, nb);
    write_reg(REG_FIELD_NAME_LENGTH, ld);
  endtask

  // Random field name; mostly usable lengths, some zero, some above eight.
  task automatic pick_field_name();
    logic [CFG_DATA_W-1:0] nb;
    logic [CFG_DATA_W-1:0] ld;
    int r;
    int i;
    r  = $urandom_range(99);
    ld = {$urandom(), $urandom()};
    if (r < 70) ld[NAME_LENGTH_W-1:0] = NAME_LENGTH_W'($urandom_range(1, 8));
    else if (r < 80) ld[NAME_LENGTH_W-1:0] = '0;
    else ld[NAME_LENGTH_W-1:0] = NAME_LENGTH_W'($urandom_range(9, 15));
    if ($urandom_range(9) == 0) begin
      nb = {$urandom(), $urandom()};
    end else begin
      for (i = 0; i < 8; i++) nb[8*i +: 8] = pick_name_char();
    end
    set_field_name(nb, ld);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int p;
    text_if.valid     = 1'b0;
    text_if.text_byte = '0;
    text_if.is_last   = 1'b0;
    verdict_if.ready  = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_FIELD_NAME_BYTES;
    cfg_if.data       = '0;
    name_bytes        = '0;
    name_len          = NAME_LENGTH_W'(1);
    clear_parse();
    rst = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset name is a single zero byte: no key can carry it, so reject all.
    send_str("{\"a\":\"v\"}");
    send_str("{\"\":\"v\"}");
    wait_idle();

    // Field name "id".
    set_field_name(64'h0000_0000_0000_6469, 64'd2);
    send_str("{\"id\":\"x\"}");
    // Whitespace around every token and every legal escape in the value.
    add_str(" \t{\n\"id\" : \"a\\\"\\\\\\/\\b\\f\\n\\r\\tz\"");
    add_byte(CH_CR);
    add_str("}\n ");
    send_text();
    send_str("{\"id\":\"\"}");           // empty value
    send_str("{\"idx\":\"v\"}");         // key longer than the name
    send_str("{\"i\":\"v\"}");           // key shorter than the name
    send_str("{\"id\":\"a\\qb\"}");      // unknown escape in the value
    send_str("{\"\\id\":\"v\"}");        // unknown escape in the key
    add_str("{\"id\":\"a"); add_byte(8'h01); add_str("\"}"); send_text();  // raw control
    add_str("{\"id\":\"v\""); add_byte(CH_NUL); add_str("}"); send_text(); // zero before brace
    add_str("{\"id\":\"v\"}"); add_byte(CH_NUL); add_str("x{"); send_text(); // junk after zero
    send_str("{\"id\":\"v\"");           // text ends before the closing brace
    send_str("{\"id\":\"v\"}x");         // trailing garbage
    send_str("x{\"id\":\"v\"}");         // bytes after a syntax error
    add_byte(CH_NUL); send_text();       // lone zero byte
    add_str("{\"id\":\""); add_byte(8'hFF); add_byte(8'h80); add_str("\"}"); send_text();
    wait_idle();

    // Length zero: nothing matches.
    set_field_name(64'h0000_0000_0000_6469, 64'd0);
    send_str("{\"\":\"v\"}");
    send_str("{\"id\":\"v\"}");
    wait_idle();

    // Eight-byte name full of escapes, length fifteen read as eight.
    set_field_name(64'h080A_2F63_5C62_2261, {$urandom(), $urandom()} | 64'hF);
    build_text(TEXT_GOOD); send_text();
    build_text(TEXT_GOOD); send_text();
    build_text(TEXT_KEY_LONG); send_text();
    build_text(TEXT_KEY_SHORT); send_text();
    wait_idle();

    // All-ones name.
    set_field_name({NAME_BYTES_W{1'b1}}, 64'd8);
    build_text(TEXT_GOOD); send_text();
    build_text(TEXT_KEY_WRONG); send_text();
    wait_idle();

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (p = 0; p < 4; p++) begin
      send_idle_pct  = send_plan[p];
      recv_stall_pct = recv_plan[p];
      repeat (2) begin
        pick_field_name();
        run_random_texts(TEXTS_PER_SETTING);
        wait_idle();
      end
    end

    // Hold the receiver off while the sender keeps offering, so input backs up.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pick_field_name();
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    repeat (PRESSURE_TEXTS) begin
      build_text(TEXT_GOOD);
      send_text();
    end
    wait_idle();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/jsfv_pkg.sv
rtl/jsfv_if.sv
rtl/json_single_field_validator_top.sv
rtl/jsfv_checker.sv
tb/json_single_field_validator_top_tb.sv
